FILE: hw/rtl/mste_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mste_pkg
// Shared constants, register codes and control types for the maze
// spanning-tree edge filter.
// ----------------------------------------------------------------------------
package mste_pkg;

  localparam int MAX_CELLS_DEF = 4096;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;
  localparam int GRID_W     = 7;
  localparam int LIMIT_W    = 2;
  localparam int COORD_W    = 6;
  localparam int POS_W      = 14;

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SIDE_LIMIT  = 2'd2;

  localparam logic [GRID_W-1:0]  GRID_WIDTH_RST  = 7'd16;
  localparam logic [GRID_W-1:0]  GRID_HEIGHT_RST = 7'd16;
  localparam logic [LIMIT_W-1:0] SIDE_LIMIT_RST  = 2'd3;

  typedef struct packed {
    logic clear;
    logic load;
    logic seek_a;
    logic seek_b;
    logic step;
    logic fin_a;
    logic fin_b;
    logic decide;
    logic upd_a;
    logic upd_b;
    logic emit;
  } mste_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic in_grid;
    logic link_end;
    logic accept;
  } mste_status_t;

endpackage

FILE: hw/rtl/mste_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mste_ctrl
// Sequencer for the edge filter: clearing pass, two root walks, the union
// update and the result register handshake.
// ----------------------------------------------------------------------------
module mste_ctrl
  import mste_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  output logic         out_valid,
  input  logic         out_ready,
  input  mste_status_t status,
  output mste_cmd_t    cmd
);

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_CHECK  = 4'd2;
  localparam logic [3:0] S_SEEK_A = 4'd3;
  localparam logic [3:0] S_WALK_A = 4'd4;
  localparam logic [3:0] S_SEEK_B = 4'd5;
  localparam logic [3:0] S_WALK_B = 4'd6;
  localparam logic [3:0] S_DECIDE = 4'd7;
  localparam logic [3:0] S_UPD_A  = 4'd8;
  localparam logic [3:0] S_UPD_B  = 4'd9;
  localparam logic [3:0] S_DONE   = 4'd10;

  logic [3:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (status.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        state_nxt = status.in_grid ? S_SEEK_A : S_DONE;
      end
      S_SEEK_A: begin
        cmd.seek_a = 1'b1;
        state_nxt  = S_WALK_A;
      end
      S_WALK_A: begin
        if (status.link_end) begin
          cmd.fin_a = 1'b1;
          state_nxt = S_SEEK_B;
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_SEEK_B: begin
        cmd.seek_b = 1'b1;
        state_nxt  = S_WALK_B;
      end
      S_WALK_B: begin
        if (status.link_end) begin
          cmd.fin_b = 1'b1;
          state_nxt = S_DECIDE;
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        state_nxt  = status.accept ? S_UPD_A : S_DONE;
      end
      S_UPD_A: begin
        cmd.upd_a = 1'b1;
        state_nxt = S_UPD_B;
      end
      S_UPD_B: begin
        cmd.upd_b = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    priority if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: hw/rtl/mste_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mste_datapath
// Configuration registers, parent and open-side memories, root walk
// registers, union counter and result payload.
// ----------------------------------------------------------------------------
module mste_datapath
  import mste_pkg::*;
#(
  parameter int MAX_CELLS = MAX_CELLS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [COORD_W-1:0]    in_cell_x,
  input  logic [COORD_W-1:0]    in_cell_y,
  input  logic                  in_edge_orientation,
  output logic                  out_edge_used,
  output logic                  out_all_connected,
  input  mste_cmd_t             cmd,
  output mste_status_t          status
);

  localparam int CW = $clog2(MAX_CELLS);
  localparam int XW = (CW > POS_W) ? CW : POS_W;
  localparam int DW = CW + 1;

  logic [GRID_W-1:0]  grid_width_r;
  logic [GRID_W-1:0]  grid_height_r;
  logic [LIMIT_W-1:0] side_limit_r;

  logic [CW-1:0]  par_mem [MAX_CELLS];
  logic [1:0]     osc_mem [MAX_CELLS];
  logic [CW-1:0]  par_q;
  logic [1:0]     osc_q;

  logic [CW-1:0]  clr_r;
  logic [XW-1:0]  a_r, b_r;
  logic           in_grid_r;
  logic [CW-1:0]  node_r, root_a_r;
  logic [DW-1:0]  depth_r, depth_a_r;
  logic [1:0]     osc_a_r, osc_b_r;
  logic           cap_a_r, cap_b_r;
  logic           used_r;
  logic [DW-1:0]  union_r;
  logic           edge_used_r, all_connected_r;

  logic [GRID_W-1:0]  nx, ny;
  logic [12:0]        prod_a;
  logic [13:0]        prod_b;
  logic [XW-1:0]      a_calc, b_calc;
  logic               in_grid_calc;
  logic [13:0]        cells;
  logic [CW-1:0]      a_idx, b_idx;

  logic               par_we, par_re;
  logic [CW-1:0]      par_wa, par_wd, par_ra;
  logic               osc_we, osc_re;
  logic [CW-1:0]      osc_wa, osc_ra;
  logic [1:0]         osc_wd;

  assign cfg_ready = 1'b1;

  assign a_idx = a_r[CW-1:0];
  assign b_idx = b_r[CW-1:0];

  assign nx     = {1'b0, in_cell_x} + {{(GRID_W-1){1'b0}}, in_edge_orientation};
  assign ny     = {1'b0, in_cell_y} + {{(GRID_W-1){1'b0}}, ~in_edge_orientation};
  assign prod_a = 13'(in_cell_y) * 13'(grid_width_r);
  assign prod_b = 14'(ny) * 14'(grid_width_r);
  assign a_calc = XW'(prod_a) + XW'(in_cell_x);
  assign b_calc = XW'(prod_b) + XW'(nx);

  assign in_grid_calc = (GRID_W'(in_cell_x) < grid_width_r) &&
                        (GRID_W'(in_cell_y) < grid_height_r) &&
                        (nx < grid_width_r) && (ny < grid_height_r) &&
                        (32'(a_calc) < 32'(MAX_CELLS)) &&
                        (32'(b_calc) < 32'(MAX_CELLS));

  assign cells = 14'(grid_width_r) * 14'(grid_height_r);

  assign status.clr_last = (clr_r == CW'(MAX_CELLS - 1));
  assign status.in_grid  = in_grid_r;
  assign status.link_end = (par_q == node_r);
  assign status.accept   = (osc_a_r < side_limit_r) && (osc_b_r < side_limit_r) &&
                           (root_a_r != node_r);

  always_comb begin
    par_we = 1'b0;
    par_wa = node_r;
    par_wd = node_r;
    priority if (cmd.clear) begin
      par_we = 1'b1;
      par_wa = clr_r;
      par_wd = clr_r;
    end else if (cmd.fin_a) begin
      par_we = 1'b1;
      par_wa = a_idx;
    end else if (cmd.fin_b) begin
      par_we = 1'b1;
      par_wa = b_idx;
    end else if (cmd.upd_a) begin
      par_we = 1'b1;
      if (depth_a_r > depth_r) begin
        par_wa = node_r;
        par_wd = root_a_r;
      end else begin
        par_wa = root_a_r;
        par_wd = node_r;
      end
    end
  end

  assign par_re = cmd.seek_a | cmd.seek_b | cmd.step;
  assign par_ra = cmd.seek_a ? a_idx : (cmd.seek_b ? b_idx : par_q);

  always_comb begin
    osc_we = 1'b0;
    osc_wa = clr_r;
    osc_wd = 2'd0;
    priority if (cmd.clear) begin
      osc_we = 1'b1;
    end else if (cmd.upd_a) begin
      osc_we = 1'b1;
      osc_wa = a_idx;
      osc_wd = osc_a_r + 2'd1;
    end else if (cmd.upd_b) begin
      osc_we = 1'b1;
      osc_wa = b_idx;
      osc_wd = osc_b_r + 2'd1;
    end
  end

  assign osc_re = cmd.seek_a | cmd.seek_b;
  assign osc_ra = cmd.seek_a ? a_idx : b_idx;

  always_ff @(posedge clk) begin
    if (par_we) begin
      par_mem[par_wa] <= par_wd;
    end
    if (par_re) begin
      par_q <= par_mem[par_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (osc_we) begin
      osc_mem[osc_wa] <= osc_wd;
    end
    if (osc_re) begin
      osc_q <= osc_mem[osc_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r  <= GRID_WIDTH_RST;
      grid_height_r <= GRID_HEIGHT_RST;
      side_limit_r  <= SIDE_LIMIT_RST;
      clr_r         <= '0;
      union_r       <= '0;
      cap_a_r       <= 1'b0;
      cap_b_r       <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_GRID_WIDTH:  grid_width_r  <= cfg_data;
          CFG_GRID_HEIGHT: grid_height_r <= cfg_data;
          CFG_SIDE_LIMIT:  side_limit_r  <= cfg_data[LIMIT_W-1:0];
          default: begin
          end
        endcase
      end
      if (cmd.clear) begin
        clr_r <= clr_r + CW'(1);
      end
      if (cmd.upd_b) begin
        union_r <= union_r + DW'(1);
      end
      cap_a_r <= cmd.seek_a;
      cap_b_r <= cmd.seek_b;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a_r       <= a_calc;
      b_r       <= b_calc;
      in_grid_r <= in_grid_calc;
      used_r    <= 1'b0;
    end
    if (cmd.seek_a) begin
      node_r  <= a_idx;
      depth_r <= '0;
    end else if (cmd.seek_b) begin
      node_r  <= b_idx;
      depth_r <= '0;
    end else if (cmd.step) begin
      node_r  <= par_q;
      depth_r <= depth_r + DW'(1);
    end
    if (cmd.fin_a) begin
      root_a_r  <= node_r;
      depth_a_r <= depth_r;
    end
    if (cap_a_r) begin
      osc_a_r <= osc_q;
    end
    if (cap_b_r) begin
      osc_b_r <= osc_q;
    end
    if (cmd.decide) begin
      used_r <= status.accept;
    end
    if (cmd.emit) begin
      edge_used_r     <= used_r;
      all_connected_r <= !used_r && ((32'(union_r) + 32'd1) >= 32'(cells));
    end
  end

  assign out_edge_used     = edge_used_r;
  assign out_all_connected = all_connected_r;

endmodule

FILE: hw/rtl/maze_spanning_tree_edge_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// maze_spanning_tree_edge_filter
// Union-find edge filter for spanning-tree maze generation.
//
// Feed grid edges (cell_x, cell_y, edge_orientation) in ascending weight
// order on the in_ channel; each transaction yields one out_ transaction
// with edge_used and all_connected. Registers grid_width, grid_height and
// side_limit are written on the cfg_ channel (always ready); the user must
// write them only while idle, as the block itself does not enforce this.
// An in-grid edge walks the parent chain of each of its two cells, reading
// one link per cycle from the single-read-port parent memory; a used edge
// then takes the union update, which writes the open-side memory for each
// cell in turn. Edges outside the grid go from the grid check straight to
// the result. One edge is processed at a time; the next one can be accepted
// in the cycle after the result is loaded, while that result waits in the
// output register. A stalled receiver holds that register and stops the
// block once the following edge is done. After reset a clearing pass over
// all MAX_CELLS cells sets every cell as its own root with no open sides;
// in_ready stays low until it ends.
// ----------------------------------------------------------------------------
module maze_spanning_tree_edge_filter
  import mste_pkg::*;
#(
  parameter int MAX_CELLS = MAX_CELLS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [COORD_W-1:0]    in_cell_x,
  input  logic [COORD_W-1:0]    in_cell_y,
  input  logic                  in_edge_orientation,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_edge_used,
  output logic                  out_all_connected
);

  mste_cmd_t    cmd;
  mste_status_t status;

  mste_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  mste_datapath #(
    .MAX_CELLS (MAX_CELLS)
  ) u_datapath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_cell_x           (in_cell_x),
    .in_cell_y           (in_cell_y),
    .in_edge_orientation (in_edge_orientation),
    .out_edge_used       (out_edge_used),
    .out_all_connected   (out_all_connected),
    .cmd                 (cmd),
    .status              (status)
  );

endmodule
